/* rtl/core/assert_macros.svh */
// assertion macros shared by the search unit modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/nmps_pkg.sv */
// shared constants and types for the nearest manhattan point search unit
`timescale 1ns / 1ps

package nmps_pkg;

    localparam int DEF_TABLE_DEPTH   = 64;
    localparam int DEF_EXCLUDE_DEPTH = 16;
    localparam int DEF_COORD_BITS    = 16;

    localparam logic [2:0] OP_CLEAR_ALL  = 3'd0;
    localparam logic [2:0] OP_ADD_POINT  = 3'd1;
    localparam logic [2:0] OP_ADD_EXCL   = 3'd2;
    localparam logic [2:0] OP_QUERY      = 3'd3;
    localparam logic [2:0] OP_CLEAR_EXCL = 3'd4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_NONE = 2'd2;

    localparam logic [16:0] DIST_MAX = 17'h1ffff;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } cell_ctl_t;

endpackage

/* rtl/core/nmps_excl_cell.sv */
// one exclusion cell: holds one excluded point and tags matching points passing by
`timescale 1ns / 1ps

module nmps_excl_cell
    import nmps_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int IDX_BITS   = 6,
    parameter int CNT_BITS   = 5,
    parameter int CELL_IDX   = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [CNT_BITS-1:0]          ex_count,
    input  logic signed [COORD_BITS-1:0] wr_x,
    input  logic signed [COORD_BITS-1:0] wr_y,
    input  cell_ctl_t                    in_ctl,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic [IDX_BITS-1:0]          in_idx,
    output cell_ctl_t                    out_ctl,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic [IDX_BITS-1:0]          out_idx
);

    logic signed [COORD_BITS-1:0] ex_x_reg;
    logic signed [COORD_BITS-1:0] ex_y_reg;
    cell_ctl_t                    ctl_reg;
    cell_ctl_t                    ctl_next;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic [IDX_BITS-1:0]          idx_reg;
    logic                         live;
    logic                         match;

    // entry takes part only once it lies below the fill count
    assign live  = CNT_BITS'(CELL_IDX) < ex_count;
    assign match = live && (ex_x_reg == in_x) && (ex_y_reg == in_y);

    always_comb
    begin
        ctl_next.valid = in_ctl.valid;
        ctl_next.hit   = in_ctl.valid && (in_ctl.hit || match);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (ex_count == CNT_BITS'(CELL_IDX)))
        begin
            ex_x_reg <= wr_x;
            ex_y_reg <= wr_y;
        end
        x_reg   <= in_x;
        y_reg   <= in_y;
        idx_reg <= in_idx;
    end

    assign out_ctl = ctl_reg;
    assign out_x   = x_reg;
    assign out_y   = y_reg;
    assign out_idx = idx_reg;

endmodule

/* rtl/core/nmps_best_unit.sv */
// distance stage and running minimum at the end of the exclusion chain
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmps_best_unit
    import nmps_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int IDX_BITS   = 6
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic signed [COORD_BITS-1:0] qx,
    input  logic signed [COORD_BITS-1:0] qy,
    input  cell_ctl_t                    in_ctl,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic [IDX_BITS-1:0]          in_idx,
    output logic                         found,
    output logic [COORD_BITS:0]          best_dist,
    output logic [IDX_BITS-1:0]          best_idx
);

    logic                  v1_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [IDX_BITS-1:0]   i1_reg;
    logic                  found_reg;
    logic [COORD_BITS:0]   best_d_reg;
    logic [IDX_BITS-1:0]   best_i_reg;

    logic [COORD_BITS:0]   ddx;
    logic [COORD_BITS:0]   ddy;
    logic [COORD_BITS:0]   negx;
    logic [COORD_BITS:0]   negy;
    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_next;
    logic [COORD_BITS:0]   dsum;
    logic                  take;

    // sign extended differences, then magnitude
    assign ddx  = {qx[COORD_BITS-1], qx} - {in_x[COORD_BITS-1], in_x};
    assign ddy  = {qy[COORD_BITS-1], qy} - {in_y[COORD_BITS-1], in_y};
    assign negx = -ddx;
    assign negy = -ddy;
    assign dx_next = ddx[COORD_BITS] ? negx[COORD_BITS-1:0] : ddx[COORD_BITS-1:0];
    assign dy_next = ddy[COORD_BITS] ? negy[COORD_BITS-1:0] : ddy[COORD_BITS-1:0];

    assign dsum = {1'b0, dx_reg} + {1'b0, dy_reg};
    // later entry wins a tie, zero distance never qualifies
    assign take = v1_reg && (dsum != '0) && (!found_reg || (dsum <= best_d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_ctl.valid && !in_ctl.hit;
            if (clear)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        i1_reg <= in_idx;
        if (take && !clear)
        begin
            best_d_reg <= dsum;
            best_i_reg <= i1_reg;
        end
    end

    assign found     = found_reg;
    assign best_dist = best_d_reg;
    assign best_idx  = best_i_reg;

    `ASSERT_CLK(a_best_nonzero, found_reg |-> (best_d_reg != '0), "best distance is zero")
    `ASSERT_NEXT(a_clear_found, clear, !found_reg, "found not cleared at query start")

endmodule

/* rtl/core/nearest_manhattan_point_search_unit.sv */
// top level of the nearest manhattan point search unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Each transaction (start high while busy is low) clears, appends a point or an
// exclusion, or runs a query; exactly one result follows, shown for one cycle with
// done high, and the receiver cannot stall it. Clear and append transactions keep
// busy low and give their result in the next cycle, so they can be issued back to
// back. A query holds busy while it scans the table and drains the chain, and its result
// shows in the cycle in which busy falls: the point table has a single read port that
// streams one stored point per cycle into a chain of EXCLUDE_DEPTH exclusion cells,
// followed by a two stage distance and minimum unit, and the chain must drain.
// The exclusion cells compare every point against every exclusion in flight, so
// the query cost grows with the table fill, not with table times exclusion depth.
module nearest_manhattan_point_search_unit
    import nmps_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int EXCLUDE_DEPTH = DEF_EXCLUDE_DEPTH,
    parameter int COORD_BITS    = DEF_COORD_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    output logic               done,
    output logic [1:0]         status,
    output logic [5:0]         best_index,
    output logic [16:0]        best_distance
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int PCW = $clog2(TABLE_DEPTH + 1);
    localparam int ECW = $clog2(EXCLUDE_DEPTH + 1);
    localparam int DCW = $clog2(EXCLUDE_DEPTH + 2);
    localparam int CB  = COORD_BITS;
    localparam int DW  = COORD_BITS + 1;
    localparam logic [DCW-1:0] DRAIN_LAST = DCW'(EXCLUDE_DEPTH + 1);

    state_t state_reg;
    state_t state_next;

    logic [PCW-1:0] pt_count_reg;
    logic [PCW-1:0] pt_count_next;
    logic [ECW-1:0] ex_count_reg;
    logic [ECW-1:0] ex_count_next;
    logic [PCW-1:0] rd_idx_reg;
    logic [PCW-1:0] rd_idx_next;
    logic [DCW-1:0] drain_cnt_reg;
    logic [DCW-1:0] drain_cnt_next;

    logic signed [CB-1:0] qx_reg;
    logic signed [CB-1:0] qy_reg;
    logic signed [CB-1:0] cx;
    logic signed [CB-1:0] cy;

    logic [2*CB-1:0] pt_mem [TABLE_DEPTH];
    logic [2*CB-1:0] rd_data_reg;
    logic            rd_valid_reg;
    logic [IW-1:0]   rd_pidx_reg;

    logic        done_reg;
    logic        done_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [5:0]  index_reg;
    logic [5:0]  index_next;
    logic [16:0] dist_reg;
    logic [16:0] dist_next;

    logic accept;
    logic issue;
    logic q_start;
    logic q_finish;
    logic pt_full;
    logic ex_full;
    logic ex_wr;

    logic          found;
    logic [DW-1:0] best_d;
    logic [IW-1:0] best_i;
    logic [5:0]    res_idx;
    logic [16:0]   res_dist;

    cell_ctl_t            ch_ctl [EXCLUDE_DEPTH+1];
    logic signed [CB-1:0] ch_x   [EXCLUDE_DEPTH+1];
    logic signed [CB-1:0] ch_y   [EXCLUDE_DEPTH+1];
    logic [IW-1:0]        ch_idx [EXCLUDE_DEPTH+1];

    // coordinates are the low COORD_BITS bits, sign extended
    generate
        if (CB <= 16)
        begin : g_coord_narrow
            assign cx = coord_x[CB-1:0];
            assign cy = coord_y[CB-1:0];
        end
        else
        begin : g_coord_wide
            assign cx = {{(CB-16){coord_x[15]}}, coord_x};
            assign cy = {{(CB-16){coord_y[15]}}, coord_y};
        end
        if (IW >= 6)
        begin : g_idx_cut
            assign res_idx = best_i[5:0];
        end
        else
        begin : g_idx_ext
            assign res_idx = 6'(best_i);
        end
        if (DW > 17)
        begin : g_dist_sat
            assign res_dist = (best_d > DW'(DIST_MAX)) ? DIST_MAX : best_d[16:0];
        end
        else
        begin : g_dist_ext
            assign res_dist = 17'(best_d);
        end
    endgenerate

    assign accept  = start && !busy;
    assign pt_full = (pt_count_reg == PCW'(TABLE_DEPTH));
    assign ex_full = (ex_count_reg == ECW'(EXCLUDE_DEPTH));
    assign ex_wr   = accept && (operation == OP_ADD_EXCL) && !ex_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_QUERY))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg == pt_count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_cnt_reg == DRAIN_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state machine outputs
    always_comb
    begin
        busy     = 1'b1;
        issue    = 1'b0;
        q_start  = 1'b0;
        q_finish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy    = 1'b0;
                q_start = start && (operation == OP_QUERY);
            end
            S_SCAN:
            begin
                issue = (rd_idx_reg != pt_count_reg);
            end
            S_DRAIN:
            begin
                q_finish = (drain_cnt_reg == DRAIN_LAST);
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // counters and result
    always_comb
    begin
        pt_count_next  = pt_count_reg;
        ex_count_next  = ex_count_reg;
        rd_idx_next    = rd_idx_reg;
        drain_cnt_next = drain_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        index_next     = index_reg;
        dist_next      = dist_reg;

        if (q_start)
        begin
            rd_idx_next = '0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end

        if (state_reg == S_DRAIN)
        begin
            drain_cnt_next = drain_cnt_reg + 1'b1;
        end
        else
        begin
            drain_cnt_next = '0;
        end

        if (accept && (operation != OP_QUERY))
        begin
            done_next   = 1'b1;
            status_next = STATUS_OK;
            index_next  = '0;
            dist_next   = '0;
            case (operation)
                OP_CLEAR_ALL:
                begin
                    pt_count_next = '0;
                    ex_count_next = '0;
                end
                OP_ADD_POINT:
                begin
                    if (pt_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        pt_count_next = pt_count_reg + 1'b1;
                    end
                end
                OP_ADD_EXCL:
                begin
                    if (ex_full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        ex_count_next = ex_count_reg + 1'b1;
                    end
                end
                OP_CLEAR_EXCL:
                begin
                    ex_count_next = '0;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
        else if (q_finish)
        begin
            done_next   = 1'b1;
            status_next = found ? STATUS_OK : STATUS_NONE;
            index_next  = found ? res_idx : 6'd0;
            dist_next   = found ? res_dist : 17'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pt_count_reg  <= '0;
            ex_count_reg  <= '0;
            rd_idx_reg    <= '0;
            drain_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pt_count_reg  <= pt_count_next;
            ex_count_reg  <= ex_count_next;
            rd_idx_reg    <= rd_idx_next;
            drain_cnt_reg <= drain_cnt_next;
            rd_valid_reg  <= issue;
            done_reg      <= done_next;
        end
    end

    // point table and query registers
    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_ADD_POINT) && !pt_full)
        begin
            pt_mem[pt_count_reg[IW-1:0]] <= {cx, cy};
        end
        rd_data_reg <= pt_mem[rd_idx_reg[IW-1:0]];
        rd_pidx_reg <= rd_idx_reg[IW-1:0];
        if (q_start)
        begin
            qx_reg <= cx;
            qy_reg <= cy;
        end
        status_reg <= status_next;
        index_reg  <= index_next;
        dist_reg   <= dist_next;
    end

    assign ch_ctl[0] = '{valid: rd_valid_reg, hit: 1'b0};
    assign ch_x[0]   = rd_data_reg[2*CB-1:CB];
    assign ch_y[0]   = rd_data_reg[CB-1:0];
    assign ch_idx[0] = rd_pidx_reg;

    generate
        for (genvar k = 0; k < EXCLUDE_DEPTH; k++)
        begin : g_cell
            nmps_excl_cell #(
                .COORD_BITS (CB),
                .IDX_BITS   (IW),
                .CNT_BITS   (ECW),
                .CELL_IDX   (k)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_en    (ex_wr),
                .ex_count (ex_count_reg),
                .wr_x     (cx),
                .wr_y     (cy),
                .in_ctl   (ch_ctl[k]),
                .in_x     (ch_x[k]),
                .in_y     (ch_y[k]),
                .in_idx   (ch_idx[k]),
                .out_ctl  (ch_ctl[k+1]),
                .out_x    (ch_x[k+1]),
                .out_y    (ch_y[k+1]),
                .out_idx  (ch_idx[k+1])
            );
        end
    endgenerate

    nmps_best_unit #(
        .COORD_BITS (CB),
        .IDX_BITS   (IW)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (q_start),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .in_ctl    (ch_ctl[EXCLUDE_DEPTH]),
        .in_x      (ch_x[EXCLUDE_DEPTH]),
        .in_y      (ch_y[EXCLUDE_DEPTH]),
        .in_idx    (ch_idx[EXCLUDE_DEPTH]),
        .found     (found),
        .best_dist (best_d),
        .best_idx  (best_i)
    );

    assign done          = done_reg;
    assign status        = status_reg;
    assign best_index    = index_reg;
    assign best_distance = dist_reg;

    `ASSERT_CLK(a_done_cause,
        done_reg |-> $past(q_finish || (accept && (operation != OP_QUERY))),
        "result without a transaction")
    `ASSERT_CLK(a_pt_bound, pt_count_reg <= PCW'(TABLE_DEPTH), "point count beyond table depth")
    `ASSERT_CLK(a_read_in_scan, rd_valid_reg |-> (state_reg == S_SCAN), "table read outside scan")

endmodule
